FILE: rtl/ifd_pkg.sv
// shared types and constants of the filter with derivative output
package ifd_pkg;

    localparam int CH_W       = 5;
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int SRATE_W    = 16;
    localparam int RATE_W     = 40;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 52;
    localparam int FRAC_W     = 22;
    localparam int MID_W      = ACC_W - FRAC_W;
    localparam int SCL_W      = MID_W + COEF_W;
    localparam int YW_W       = SCL_W - FRAC_W;
    localparam int DY_W       = SAMPLE_W + 1;
    localparam int RPROD_W    = DY_W + SRATE_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TAP_W      = 3;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    localparam logic [CFG_IDX_W-1:0] CFG_B0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SRATE = 3'd6;

    localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
    localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
    localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
    localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
    localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] COEF_ONE   = 24'sd4194304;
    localparam logic [SRATE_W-1:0]       SRATE_INIT = 16'd1000;
    localparam logic [ACC_W-1:0]         RND_HALF   = 52'd2097152;

    localparam logic signed [YW_W-1:0]    Y_MAX = 32'sd8388607;
    localparam logic signed [YW_W-1:0]    Y_MIN = -32'sd8388608;
    localparam logic signed [RPROD_W-1:0] R_MAX = 42'sd549755813887;
    localparam logic signed [RPROD_W-1:0] R_MIN = -42'sd549755813888;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
    } t_hist;

endpackage

FILE: rtl/ifd_hist_mem.sv
// per-channel history memory with valid bits, unwritten entries read as zero
module ifd_hist_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output ifd_pkg::t_hist    o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  ifd_pkg::t_hist    i_wr_data
);

    ifd_pkg::t_hist r_mem [DEPTH];
    ifd_pkg::t_hist r_rd_data;
    logic [DEPTH-1:0] r_vld;
    logic r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: rtl/iir_filter_with_derivative.sv
// top level: multichannel second-order iir filter with rate output
//
// config port: i_cfg_we writes i_cfg_data into register i_cfg_idx at the clock edge
//   (0 b0, 1 b1, 2 b2, 3 a1, 4 a2, 5 1/a0, 6 sample rate); other indexes are ignored.
//   write only while no transaction is in flight.
// input stream s_axis: one transaction carries a channel number and a sample.
// output stream m_axis: one result per input, channel, filtered sample and rate.
// each accepted item goes through these steps from accept to output valid: five multiply
//   steps on one shared 24x24 multiplier, accumulate, round, scale by 1/a0,
//   saturate, rate multiply, then write back of the channel history.
// one item is processed at a time, so the input takes a new item only once the last
//   one has been written to the output register.
// the output register holds a finished result; the next item is processed while
//   it waits, and its result holds in the last step until the register is free.
// reset restores the default coefficients and marks every channel history as zero.
// channels at or above CHANNELS return zero filtered and rate values and leave all history untouched.
module iir_filter_with_derivative #(
    parameter int CHANNELS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ifd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ifd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // channel [4:0], sample [28:5], zero [31:29]
    input  logic [ifd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_channel [4:0], filtered [28:5], rate_of_change [68:29], zero [71:69]
    output logic [ifd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_FIN  = 8'b0000_0100,
        S_RND  = 8'b0000_1000,
        S_SCL  = 8'b0001_0000,
        S_SAT  = 8'b0010_0000,
        S_RATE = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [ifd_pkg::COEF_W-1:0] r_b0, r_b1, r_b2, r_a1, r_a2, r_recip;
    logic [ifd_pkg::SRATE_W-1:0]       r_srate;

    logic [ifd_pkg::CH_W-1:0]           r_ch;
    logic signed [ifd_pkg::SAMPLE_W-1:0] r_x;
    logic                               r_ok;
    logic [ifd_pkg::TAP_W-1:0]          r_tap;
    logic signed [ifd_pkg::PROD_W-1:0]  r_prod;
    logic                               r_sub;
    logic signed [ifd_pkg::ACC_W-1:0]   r_acc;
    logic signed [ifd_pkg::MID_W-1:0]   r_mid;
    logic signed [ifd_pkg::SCL_W-1:0]   r_scl;
    logic signed [ifd_pkg::SAMPLE_W-1:0] r_y;
    logic signed [ifd_pkg::RPROD_W-1:0] r_rprod;

    logic                               r_out_vld;
    logic [ifd_pkg::OUT_TDATA_W-1:0]    r_out;

    logic [ifd_pkg::CH_W-1:0]            w_in_ch;
    logic signed [ifd_pkg::SAMPLE_W-1:0] w_in_x;
    logic                                w_in_ok;
    logic                                w_accept;
    ifd_pkg::t_hist                      w_rd, w_hist, w_wr;
    logic                                w_wr_en;
    logic                                w_out_free;
    logic signed [ifd_pkg::COEF_W-1:0]   w_coef;
    logic signed [ifd_pkg::SAMPLE_W-1:0] w_opnd;
    logic signed [ifd_pkg::ACC_W-1:0]    w_acc_rnd;
    logic signed [ifd_pkg::SCL_W-1:0]    w_scl_rnd;
    logic signed [ifd_pkg::YW_W-1:0]     w_y_wide;
    logic signed [ifd_pkg::SAMPLE_W-1:0] w_y_sat;
    logic signed [ifd_pkg::DY_W-1:0]     w_dy;
    logic signed [ifd_pkg::RATE_W-1:0]   w_rate;

    assign w_in_ch  = s_axis_tdata[ifd_pkg::CH_W-1:0];
    assign w_in_x   = s_axis_tdata[ifd_pkg::CH_W +: ifd_pkg::SAMPLE_W];
    assign w_in_ok  = 32'(w_in_ch) < 32'(CHANNELS);
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_vld || m_axis_tready;

    ifd_hist_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept && w_in_ok),
        .i_rd_addr (AW'(w_in_ch)),
        .o_rd_data (w_rd),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(r_ch)),
        .i_wr_data (w_wr)
    );

    assign w_hist  = r_ok ? w_rd : '0;
    assign w_wr_en = (r_state == S_OUT) && w_out_free && r_ok;
    assign w_wr    = '{x1: r_x, x2: w_hist.x1, y1: r_y, y2: w_hist.y1};

    always_comb begin
        unique case (r_tap)
            ifd_pkg::TAP_B0: begin
                w_coef = r_b0;
                w_opnd = r_x;
            end
            ifd_pkg::TAP_B1: begin
                w_coef = r_b1;
                w_opnd = w_hist.x1;
            end
            ifd_pkg::TAP_B2: begin
                w_coef = r_b2;
                w_opnd = w_hist.x2;
            end
            ifd_pkg::TAP_A1: begin
                w_coef = r_a1;
                w_opnd = w_hist.y1;
            end
            default: begin
                w_coef = r_a2;
                w_opnd = w_hist.y2;
            end
        endcase
    end

    assign w_acc_rnd = r_acc + $signed(ifd_pkg::RND_HALF);
    assign w_scl_rnd = r_scl + $signed(ifd_pkg::SCL_W'(ifd_pkg::RND_HALF));
    assign w_y_wide  = $signed(w_scl_rnd[ifd_pkg::SCL_W-1:ifd_pkg::FRAC_W]);

    always_comb begin
        priority if (w_y_wide > ifd_pkg::Y_MAX) begin
            w_y_sat = ifd_pkg::SAMPLE_W'(ifd_pkg::Y_MAX);
        end else if (w_y_wide < ifd_pkg::Y_MIN) begin
            w_y_sat = ifd_pkg::SAMPLE_W'(ifd_pkg::Y_MIN);
        end else begin
            w_y_sat = w_y_wide[ifd_pkg::SAMPLE_W-1:0];
        end
    end

    assign w_dy = ifd_pkg::DY_W'(r_y) - ifd_pkg::DY_W'(w_hist.y1);

    always_comb begin
        priority if (r_rprod > ifd_pkg::R_MAX) begin
            w_rate = ifd_pkg::RATE_W'(ifd_pkg::R_MAX);
        end else if (r_rprod < ifd_pkg::R_MIN) begin
            w_rate = ifd_pkg::RATE_W'(ifd_pkg::R_MIN);
        end else begin
            w_rate = r_rprod[ifd_pkg::RATE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_tap == ifd_pkg::TAP_A2) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = S_RND;
            S_RND:  n_state = S_SCL;
            S_SCL:  n_state = S_SAT;
            S_SAT:  n_state = S_RATE;
            S_RATE: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_b0      <= ifd_pkg::COEF_ONE;
            r_b1      <= '0;
            r_b2      <= '0;
            r_a1      <= '0;
            r_a2      <= '0;
            r_recip   <= ifd_pkg::COEF_ONE;
            r_srate   <= ifd_pkg::SRATE_INIT;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ifd_pkg::CFG_B0:    r_b0    <= i_cfg_data;
                    ifd_pkg::CFG_B1:    r_b1    <= i_cfg_data;
                    ifd_pkg::CFG_B2:    r_b2    <= i_cfg_data;
                    ifd_pkg::CFG_A1:    r_a1    <= i_cfg_data;
                    ifd_pkg::CFG_A2:    r_a2    <= i_cfg_data;
                    ifd_pkg::CFG_RECIP: r_recip <= i_cfg_data;
                    ifd_pkg::CFG_SRATE: r_srate <= i_cfg_data[ifd_pkg::SRATE_W-1:0];
                    default: ;
                endcase
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_ch  <= w_in_ch;
                    r_x   <= w_in_x;
                    r_ok  <= w_in_ok;
                    r_tap <= ifd_pkg::TAP_B0;
                    r_acc <= '0;
                end
            end
            S_MUL: begin
                r_prod <= w_coef * w_opnd;
                r_sub  <= (r_tap == ifd_pkg::TAP_A1) || (r_tap == ifd_pkg::TAP_A2);
                r_tap  <= r_tap + 1'b1;
                if (r_tap != ifd_pkg::TAP_B0) begin
                    r_acc <= r_sub ? r_acc - ifd_pkg::ACC_W'(r_prod)
                                   : r_acc + ifd_pkg::ACC_W'(r_prod);
                end
            end
            S_FIN: begin
                r_acc <= r_sub ? r_acc - ifd_pkg::ACC_W'(r_prod)
                               : r_acc + ifd_pkg::ACC_W'(r_prod);
            end
            S_RND: begin
                r_mid <= w_acc_rnd[ifd_pkg::ACC_W-1:ifd_pkg::FRAC_W];
            end
            S_SCL: begin
                r_scl <= r_mid * r_recip;
            end
            S_SAT: begin
                r_y <= r_ok ? w_y_sat : '0;
            end
            S_RATE: begin
                r_rprod <= w_dy * $signed({1'b0, r_srate});
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out <= {3'b000, w_rate, r_y, r_ch};
                end
            end
        endcase
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

FILE: rtl/ifd_checker.sv
// port-level checks of the filter top level, attached by bind
module ifd_port_checks (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ifd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // reset leaves the output empty and the input open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("state after reset wrong");

    // one item in flight: input stays closed after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input accepted while item in flight");

    // no result shows up right after an input transaction
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result too early");

    // stalled output holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output dropped under stall");

endmodule

bind iir_filter_with_derivative ifd_port_checks u_ifd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/ifd_checker.sv
`timescale 1ns / 100ps
// predictor and scoreboard for the multichannel iir filter with rate output
module ifd_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ifd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ifd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    // channel [4:0], sample [28:5], zero [31:29]
    input  logic [ifd_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    // out_channel [4:0], filtered [28:5], rate_of_change [68:29], zero [71:69]
    input  logic [ifd_pkg::OUT_TDATA_W-1:0]    i_out_data,
    output int                                 o_errors,
    output int                                 o_pending
);
    import ifd_pkg::*;

    localparam int NUM_CH = 1 << CH_W;
    localparam longint SAMPLE_HI = 64'sd8388607;
    localparam longint SAMPLE_LO = -64'sd8388608;
    localparam longint RATE_HI = 64'sd549755813887;
    localparam longint RATE_LO = -64'sd549755813888;

    typedef struct packed {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] filt;
        logic signed [RATE_W-1:0]   rate;
    } t_filter_result;

    logic signed [COEF_W-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, coef_recip;
    logic [SRATE_W-1:0]         srate;
    logic signed [SAMPLE_W-1:0] x_one [NUM_CH];
    logic signed [SAMPLE_W-1:0] x_two [NUM_CH];
    logic signed [SAMPLE_W-1:0] y_one [NUM_CH];
    logic signed [SAMPLE_W-1:0] y_two [NUM_CH];
    t_filter_result             due_results [$];
    int                         errors = 0;
    int                         pending_count = 0;

    assign o_errors  = errors;
    assign o_pending = pending_count;

    function automatic longint round_q22(input longint v);
        return (v + 64'sd2097152) >>> FRAC_W;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // one filter step on a channel, history updated in place
    function automatic t_filter_result filter_step(input logic [CH_W-1:0] ch,
                                                   input logic signed [SAMPLE_W-1:0] x);
        longint         acc, mid, y, slope;
        t_filter_result r;
        acc = longint'(coef_b0) * longint'(x)
            + longint'(coef_b1) * longint'(x_one[ch])
            + longint'(coef_b2) * longint'(x_two[ch])
            - longint'(coef_a1) * longint'(y_one[ch])
            - longint'(coef_a2) * longint'(y_two[ch]);
        mid = round_q22(acc);
        y = clamp(round_q22(mid * longint'(coef_recip)), SAMPLE_HI == 0 ? 0 : SAMPLE_LO,
                  SAMPLE_HI);
        slope = clamp((y - longint'(y_one[ch])) * longint'(srate), RATE_LO, RATE_HI);
        x_two[ch] = x_one[ch];
        x_one[ch] = x;
        y_two[ch] = y_one[ch];
        y_one[ch] = y[SAMPLE_W-1:0];
        r.ch   = ch;
        r.filt = y[SAMPLE_W-1:0];
        r.rate = slope[RATE_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_filter_result want, got;
        if (!i_rst_n) begin
            coef_b0    = COEF_ONE;
            coef_b1    = '0;
            coef_b2    = '0;
            coef_a1    = '0;
            coef_a2    = '0;
            coef_recip = COEF_ONE;
            srate      = SRATE_INIT;
            for (int i = 0; i < NUM_CH; i++) begin
                x_one[i] = '0;
                x_two[i] = '0;
                y_one[i] = '0;
                y_two[i] = '0;
            end
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_B0:    coef_b0    = i_cfg_data;
                    CFG_B1:    coef_b1    = i_cfg_data;
                    CFG_B2:    coef_b2    = i_cfg_data;
                    CFG_A1:    coef_a1    = i_cfg_data;
                    CFG_A2:    coef_a2    = i_cfg_data;
                    CFG_RECIP: coef_recip = i_cfg_data;
                    CFG_SRATE: srate      = i_cfg_data[SRATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.ch   = i_out_data[CH_W-1:0];
                got.filt = i_out_data[CH_W +: SAMPLE_W];
                got.rate = i_out_data[CH_W+SAMPLE_W +: RATE_W];
                if (due_results.size() == 0) begin
                    $display("%0t unexpected result: ch %0d filtered %0d rate %0d",
                             $time, got.ch, got.filt, got.rate);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    if (got != want) begin
                        $display("%0t mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                                 $time, want.ch, want.filt, want.rate,
                                 got.ch, got.filt, got.rate);
                        errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                due_results.push_back(filter_step(i_in_data[CH_W-1:0],
                                                  i_in_data[CH_W +: SAMPLE_W]));
        end
        pending_count = due_results.size();
    end

endmodule

FILE: tb/tb_iir_filter_with_derivative.sv
`timescale 1ns / 100ps
// testbench top: stimulus, flow control and verdict for the iir filter with rate output
module tb_iir_filter_with_derivative;
    import ifd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 100;

    typedef enum {CFG_STYLE_STABLE, CFG_STYLE_WILD, CFG_STYLE_EDGE} t_cfg_style;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    int                     errors;
    int                     pending;
    int                     quiet_cycles = 0;
    bit                     idle_on = 1'b1;
    bit                     stall_req = 1'b0;

    iir_filter_with_derivative i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ifd_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver with random backpressure and an occasional long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                stall_req = 1'b0;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 10);
            end
        end
    end

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        while (idle_on && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, smp, ch};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef(input t_cfg_style style,
                                                    input int unsigned span);
        logic [COEF_W-1:0] corners [7];
        int unsigned       v;
        corners = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h400000,
                    24'hC00000, 24'h000001, 24'hFFFFFF};
        case (style)
            CFG_STYLE_STABLE: begin
                v = $urandom_range(0, 2 * span) - span;
                return v[COEF_W-1:0];
            end
            CFG_STYLE_WILD: begin
                v = $urandom();
                return v[COEF_W-1:0];
            end
            default: return corners[$urandom_range(0, 6)];
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_srate(input t_cfg_style style);
        logic [SRATE_W-1:0] corners [4];
        logic [7:0]         upper;
        int unsigned        v;
        corners = '{16'd1, 16'd65535, 16'd0, 16'd1000};
        upper = 8'($urandom_range(0, 255));
        case (style)
            CFG_STYLE_STABLE: v = $urandom_range(1, 65535);
            CFG_STYLE_WILD:   v = $urandom();
            default:          v = 32'(corners[$urandom_range(0, 3)]);
        endcase
        return {upper, v[SRATE_W-1:0]};
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 32'h007FFFFF : 32'h00800000;
            1, 2, 3: v = $urandom_range(0, 131072) - 65536;
            default: v = $urandom();
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic load_config(input t_cfg_style style);
        int unsigned recip;
        recip = 4194304 + $urandom_range(0, 2097152) - 1048576;
        write_reg(CFG_B0, pick_coef(style, 1 << 20));
        write_reg(CFG_B1, pick_coef(style, 1 << 20));
        write_reg(CFG_B2, pick_coef(style, 1 << 20));
        write_reg(CFG_A1, pick_coef(style, 1 << 21));
        write_reg(CFG_A2, pick_coef(style, 1 << 20));
        write_reg(CFG_RECIP, (style == CFG_STYLE_STABLE) ? recip[COEF_W-1:0]
                                                         : pick_coef(style, 0));
        write_reg(CFG_SRATE, pick_srate(style));
        if ($urandom_range(0, 1))
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    endtask

    task automatic run_phase(input t_cfg_style style, input bit hold, input bit no_gaps);
        logic [CH_W-1:0] ch;
        wait_idle();
        load_config(style);
        idle_on = !no_gaps;
        if (hold)
            stall_req = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            ch = CH_W'(($urandom_range(0, 9) < 6) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 31));
            send_sample(ch, pick_sample());
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default coefficients: unity gain, rate scale 1000
        send_sample(5'd0, 24'h7FFFFF);
        send_sample(5'd0, 24'h800000);
        send_sample(5'd31, 24'h000001);
        send_sample(5'd31, 24'hFFFFFF);
        send_sample(5'd0, 24'h000000);

        // extreme taps, rate scale from a too-wide write, ignored index
        wait_idle();
        write_reg(CFG_B0, 24'h7FFFFF);
        write_reg(CFG_B1, 24'h800000);
        write_reg(CFG_B2, 24'h7FFFFF);
        write_reg(CFG_A1, 24'h800000);
        write_reg(CFG_A2, 24'h7FFFFF);
        write_reg(CFG_RECIP, 24'h7FFFFF);
        write_reg(CFG_SRATE, 24'hFFFFFF);
        write_reg(CFG_UNUSED, 24'h123456);
        send_sample(5'd5, 24'h7FFFFF);
        send_sample(5'd5, 24'h800000);
        send_sample(5'd5, 24'h7FFFFF);
        send_sample(5'd5, 24'h000000);

        // negative reciprocal and zero rate scale
        wait_idle();
        write_reg(CFG_RECIP, 24'h800000);
        write_reg(CFG_B0, 24'h400000);
        write_reg(CFG_SRATE, 24'hAB0000);
        send_sample(5'd7, 24'h010000);
        send_sample(5'd7, 24'hFF0000);
        send_sample(5'd31, 24'h7FFFFF);
        send_sample(5'd31, 24'h800000);

        wait_idle();
        write_reg(CFG_SRATE, 24'h000001);
        send_sample(5'd7, 24'h123456);
        send_sample(5'd7, 24'h800000);

        run_phase(CFG_STYLE_STABLE, 1'b0, 1'b0);
        run_phase(CFG_STYLE_WILD, 1'b0, 1'b0);
        run_phase(CFG_STYLE_EDGE, 1'b0, 1'b0);
        run_phase(CFG_STYLE_STABLE, 1'b1, 1'b0);
        run_phase(CFG_STYLE_STABLE, 1'b0, 1'b1);
        run_phase(CFG_STYLE_WILD, 1'b0, 1'b0);
        run_phase(CFG_STYLE_EDGE, 1'b0, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
